### rtl/vfv_pkg.sv
// vfv_pkg: shared types and constants of the voxel face visibility block
// opcode and register index codes, the queued command and the configuration bundle
// no dependencies
`default_nettype none

package vfv_pkg;

  localparam int GRASS_LAYER = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_AW      = 5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_FILL  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_AIR     = 3'd0,
    REG_STONE   = 3'd1,
    REG_DIRT    = 3'd2,
    REG_GRASS   = 3'd3,
    REG_CHUNK_X = 3'd4,
    REG_CHUNK_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    op_t        op;
    logic       in_grid;
    logic [5:0] nb_in;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [3:0] tin;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  air;
    logic [3:0]  stone;
    logic [3:0]  dirt;
    logic [3:0]  grass;
    logic [11:0] chunk_x;
    logic [11:0] chunk_z;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/vfv_cfg.sv
// vfv_cfg: configuration registers behind the register bus port
// uses vfv_pkg for register codes and the configuration bundle
`default_nettype none

module vfv_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vfv_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output vfv_pkg::cfg_t             cfg
);
  import vfv_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air     <= 4'd0;
      cfg_r.stone   <= 4'd1;
      cfg_r.dirt    <= 4'd2;
      cfg_r.grass   <= 4'd3;
      cfg_r.chunk_x <= 12'd0;
      cfg_r.chunk_z <= 12'd0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_AIR:     cfg_r.air     <= pwdata[3:0];
        REG_STONE:   cfg_r.stone   <= pwdata[3:0];
        REG_DIRT:    cfg_r.dirt    <= pwdata[3:0];
        REG_GRASS:   cfg_r.grass   <= pwdata[3:0];
        REG_CHUNK_X: cfg_r.chunk_x <= pwdata[11:0];
        REG_CHUNK_Z: cfg_r.chunk_z <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AIR:     prdata = {28'd0, cfg_r.air};
      REG_STONE:   prdata = {28'd0, cfg_r.stone};
      REG_DIRT:    prdata = {28'd0, cfg_r.dirt};
      REG_GRASS:   prdata = {28'd0, cfg_r.grass};
      REG_CHUNK_X: prdata = {20'd0, cfg_r.chunk_x};
      REG_CHUNK_Z: prdata = {20'd0, cfg_r.chunk_z};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/vfv_front.sv
// vfv_front: input side, decodes the opcode and works out grid bounds per beat
// uses vfv_pkg for the command type; feeds vfv_queue
`default_nettype none

module vfv_front #(
  parameter int GRID_SIZE = 16
) (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_opcode,
  input  logic [3:0]    in_coord_x,
  input  logic [3:0]    in_coord_y,
  input  logic [3:0]    in_coord_z,
  input  logic [3:0]    in_type_in,
  input  logic          q_full,
  output logic          q_push,
  output vfv_pkg::cmd_t q_cmd
);
  import vfv_pkg::*;

  localparam int CB = $clog2(GRID_SIZE);
  localparam int CW = (CB > 4) ? CB : 4;
  localparam logic [CW-1:0] GMAX = CW'(GRID_SIZE - 1);

  logic [CW-1:0] xe, ye, ze;

  assign xe = CW'(in_coord_x);
  assign ye = CW'(in_coord_y);
  assign ze = CW'(in_coord_z);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.op       = op_t'(in_opcode);
    q_cmd.in_grid  = (xe <= GMAX) && (ye <= GMAX) && (ze <= GMAX);
    q_cmd.nb_in[0] = ze < GMAX;
    q_cmd.nb_in[1] = ze != '0;
    q_cmd.nb_in[2] = xe != '0;
    q_cmd.nb_in[3] = xe < GMAX;
    q_cmd.nb_in[4] = ye < GMAX;
    q_cmd.nb_in[5] = ye != '0;
    q_cmd.x        = in_coord_x;
    q_cmd.y        = in_coord_y;
    q_cmd.z        = in_coord_z;
    q_cmd.tin      = in_type_in;
  end

endmodule

`default_nettype wire

### rtl/vfv_queue.sv
// vfv_queue: short command queue between the front and the back end
// uses vfv_pkg for the command type and queue depth
`default_nettype none

module vfv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vfv_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output vfv_pkg::cmd_t cmd_out
);
  import vfv_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PMAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [NW-1:0] NFULL = NW'(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full    = count_r == NFULL;
  assign valid   = count_r != '0;
  assign cmd_out = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PMAX) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PMAX) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vfv_back.sv
// vfv_back: cell store with two read ports, query sequencer, fill and clear sweeps
// and the result register; uses vfv_pkg, takes commands from vfv_queue
`default_nettype none

module vfv_back #(
  parameter int GRID_SIZE = 16,
  parameter int TYPE_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vfv_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  vfv_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_type_out,
  output logic [5:0]         out_face_mask,
  output logic signed [15:0] out_world_x,
  output logic [3:0]         out_world_y,
  output logic signed [15:0] out_world_z
);
  import vfv_pkg::*;

  localparam int CB    = $clog2(GRID_SIZE);
  localparam int CW    = (CB > 4) ? CB : 4;
  localparam int AW    = 3 * CB;
  localparam int DEPTH = 1 << AW;
  localparam int TB    = TYPE_BITS;
  localparam logic [CB-1:0] CMAX = CB'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_FILL,
    ST_DONE
  } state_t;

  state_t        state_r;
  logic [2:0]    step_r;
  cmd_t          cmd_r;
  logic [CB-1:0] sx_r, sy_r, sz_r;
  logic [TB:0]   centre_r;
  logic [4:0]    nb_solid_r;
  logic [3:0]    res_type_r;
  logic [5:0]    res_mask_r;
  logic [15:0]   res_wx_r, res_wz_r;
  logic [3:0]    res_wy_r;
  logic          out_valid_r;
  logic [3:0]    out_type_r;
  logic [5:0]    out_mask_r;
  logic [15:0]   out_wx_r, out_wz_r;
  logic [3:0]    out_wy_r;

  logic [TB:0]   mem [DEPTH];
  logic [TB:0]   rd_a_r, rd_b_r;
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [TB:0]   wdata;

  logic [TB-1:0] air_t, cen_type;
  logic [CB-1:0] cx, cy, cz, cxp, cxm, cyp, cym, czp, czm;
  logic          solid_a, solid_b, cen_solid, sweep_end, edge_cell;
  logic [CW-1:0] sye;
  logic [TB-1:0] pattern;
  logic [5:0]    exposed, mask;
  logic          out_free;

  assign air_t    = TB'(cfg.air);
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  assign cx  = CB'(cmd_r.x);
  assign cy  = CB'(cmd_r.y);
  assign cz  = CB'(cmd_r.z);
  assign cxp = cx + CB'(1);
  assign cxm = cx - CB'(1);
  assign cyp = cy + CB'(1);
  assign cym = cy - CB'(1);
  assign czp = cz + CB'(1);
  assign czm = cz - CB'(1);

  always_comb begin
    unique case (step_r)
      3'd0: begin
        raddr_a = {cx, cy, cz};
        raddr_b = {cx, cy, czp};
      end
      3'd1: begin
        raddr_a = {cx, cy, czm};
        raddr_b = {cxm, cy, cz};
      end
      3'd2: begin
        raddr_a = {cxp, cy, cz};
        raddr_b = {cx, cyp, cz};
      end
      default: begin
        raddr_a = {cx, cym, cz};
        raddr_b = {cx, cym, cz};
      end
    endcase
  end

  // stored entry: written flag above the type code
  assign solid_a   = rd_a_r[TB] && (rd_a_r[TB-1:0] != air_t);
  assign solid_b   = rd_b_r[TB] && (rd_b_r[TB-1:0] != air_t);
  assign cen_type  = centre_r[TB] ? centre_r[TB-1:0] : air_t;
  assign cen_solid = cen_type != air_t;
  assign exposed   = ~(cmd_r.nb_in & {solid_a, nb_solid_r});
  assign mask      = (cmd_r.in_grid && cen_solid) ? exposed : 6'd0;

  assign sye       = CW'(sy_r);
  assign sweep_end = (sx_r == CMAX) && (sy_r == CMAX) && (sz_r == CMAX);
  assign edge_cell = (sx_r == '0) || (sx_r == CMAX) || (sy_r == '0) || (sy_r == CMAX) ||
                     (sz_r == '0) || (sz_r == CMAX);

  always_comb begin
    priority if (edge_cell) begin
      pattern = TB'(cfg.stone);
    end else if (sye < CW'(GRASS_LAYER)) begin
      pattern = TB'(cfg.dirt);
    end else if (sye == CW'(GRASS_LAYER)) begin
      pattern = TB'(cfg.grass);
    end else begin
      pattern = air_t;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = {sx_r, sy_r, sz_r};
    wdata = '0;
    if (state_r == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_r == ST_FILL) begin
      we    = 1'b1;
      wdata = {1'b1, pattern};
    end else if (q_pop && q_cmd.op == OP_WRITE && q_cmd.in_grid) begin
      we    = 1'b1;
      waddr = {CB'(q_cmd.x), CB'(q_cmd.y), CB'(q_cmd.z)};
      wdata = {1'b1, TB'(q_cmd.tin)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= 3'd0;
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_CLEAR || state_r == ST_FILL) begin
        sz_r <= (sz_r == CMAX) ? '0 : sz_r + CB'(1);
        if (sz_r == CMAX) begin
          sy_r <= (sy_r == CMAX) ? '0 : sy_r + CB'(1);
          if (sy_r == CMAX) begin
            sx_r <= (sx_r == CMAX) ? '0 : sx_r + CB'(1);
          end
        end
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (sweep_end) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd_r      <= q_cmd;
            step_r     <= 3'd0;
            res_type_r <= 4'd0;
            res_mask_r <= 6'd0;
            res_wx_r   <= 16'd0;
            res_wy_r   <= 4'd0;
            res_wz_r   <= 16'd0;
            unique case (q_cmd.op)
              OP_WRITE: state_r <= ST_DONE;
              OP_QUERY: state_r <= ST_QUERY;
              OP_FILL: begin
                sx_r    <= '0;
                sy_r    <= '0;
                sz_r    <= '0;
                state_r <= ST_FILL;
              end
              OP_NOP:   state_r <= ST_DONE;
            endcase
          end
        end
        ST_QUERY: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd0: ;
            3'd1: begin
              centre_r      <= rd_a_r;
              nb_solid_r[0] <= solid_b;
            end
            3'd2: begin
              nb_solid_r[1] <= solid_a;
              nb_solid_r[2] <= solid_b;
            end
            3'd3: begin
              nb_solid_r[3] <= solid_a;
              nb_solid_r[4] <= solid_b;
            end
            default: begin
              res_type_r <= 4'(cmd_r.in_grid ? cen_type : air_t);
              res_mask_r <= mask;
              res_wx_r   <= {cfg.chunk_x, 4'd0} + {12'd0, cmd_r.x};
              res_wy_r   <= cmd_r.y;
              res_wz_r   <= {cfg.chunk_z, 4'd0} + {12'd0, cmd_r.z};
              state_r    <= ST_DONE;
            end
          endcase
        end
        ST_FILL: begin
          if (sweep_end) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_type_r  <= res_type_r;
            out_mask_r  <= res_mask_r;
            out_wx_r    <= res_wx_r;
            out_wy_r    <= res_wy_r;
            out_wz_r    <= res_wz_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_type_out  = out_type_r;
  assign out_face_mask = out_mask_r;
  assign out_world_x   = out_wx_r;
  assign out_world_y   = out_wy_r;
  assign out_world_z   = out_wz_r;

endmodule

`default_nettype wire

### rtl/voxel_face_visibility_top.sv
// voxel_face_visibility_top: voxel chunk store with hidden face culling
// depends on vfv_pkg, vfv_cfg, vfv_front, vfv_queue and vfv_back
//
// Input channel (in_*): one command beat per item, opcode write, query, fill or no-op.
// Result channel (out_*): exactly one result beat per command, in command order;
// only a query carries data, every other result is all zero.
// Register port: six configuration registers at byte address 4*i; the user must write
// them only while the block is idle, which it does not enforce; pready is tied high.
// Commands pass through a two-entry queue into a back end that owns the cell store.
// The store has one write port and two registered read ports; a query reads the cell
// and its six neighbours through the two read ports, two addresses per read step.
// A fill sweeps every cell, one a cycle.
// After reset the back end clears the store in a sweep over every cell; commands
// queue up meanwhile and in_stall rises once the queue is full.
// When the receiver stalls the result holds in the output register, the back end waits
// with the next result, and the queue keeps taking commands until it is full.
`default_nettype none

module voxel_face_visibility_top #(
  parameter int GRID_SIZE = 16,
  parameter int TYPE_BITS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [3:0]                 in_coord_x,
  input  logic [3:0]                 in_coord_y,
  input  logic [3:0]                 in_coord_z,
  input  logic [3:0]                 in_type_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_type_out,
  output logic [5:0]                 out_face_mask,
  output logic signed [15:0]         out_world_x,
  output logic [3:0]                 out_world_y,
  output logic signed [15:0]         out_world_z,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vfv_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import vfv_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, pop_cmd;
  logic q_full, q_push, q_valid, q_pop;

  vfv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vfv_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .in_type_in (in_type_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  vfv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .cmd_out (pop_cmd)
  );

  vfv_back #(
    .GRID_SIZE (GRID_SIZE),
    .TYPE_BITS (TYPE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_type_out  (out_type_out),
    .out_face_mask (out_face_mask),
    .out_world_x   (out_world_x),
    .out_world_y   (out_world_y),
    .out_world_z   (out_world_z)
  );

endmodule

`default_nettype wire

### tb/sv/voxel_face_visibility_top_tb.sv
// voxel_face_visibility_top_tb: self-checking bench for the voxel chunk store with face culling
// a directed table and then random write/query patches and noise, checked against a behavioural predictor
// depends on vfv_pkg and voxel_face_visibility_top
module voxel_face_visibility_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfv_pkg::*;

  typedef struct packed {
    logic [3:0]  ty;
    logic [5:0]  mask;
    logic [15:0] wx;
    logic [3:0]  wy;
    logic [15:0] wz;
  } answer_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [3:0] tin;
    logic       known;
    answer_t    ans;
  } step_row_t;

  localparam int N_DIR = 24;
  localparam answer_t NIL = '0;
  localparam step_row_t DIR_ROWS [0:N_DIR-1] = '{
    '{OP_QUERY, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, '{4'd0, 6'd0, 16'd0, 4'd0, 16'd0}},
    '{OP_QUERY, 4'd15, 4'd15, 4'd15, 4'd0,  1'b1, '{4'd0, 6'd0, 16'd15, 4'd15, 16'd15}},
    '{OP_NOP,   4'd15, 4'd15, 4'd15, 4'd15, 1'b1, NIL},
    '{OP_WRITE, 4'd0,  4'd0,  4'd0,  4'd1,  1'b1, NIL},
    '{OP_QUERY, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, '{4'd1, 6'd63, 16'd0, 4'd0, 16'd0}},
    '{OP_WRITE, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, NIL},
    '{OP_QUERY, 4'd15, 4'd15, 4'd15, 4'd0,  1'b1, '{4'd15, 6'd63, 16'd15, 4'd15, 16'd15}},
    '{OP_WRITE, 4'd1,  4'd0,  4'd0,  4'd2,  1'b0, NIL},
    '{OP_WRITE, 4'd0,  4'd0,  4'd1,  4'd3,  1'b0, NIL},
    '{OP_QUERY, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd1,  4'd0,  4'd0,  4'd0,  1'b0, NIL},
    '{OP_WRITE, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, NIL},
    '{OP_QUERY, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, '{4'd0, 6'd0, 16'd0, 4'd0, 16'd0}},
    '{OP_QUERY, 4'd1,  4'd0,  4'd0,  4'd0,  1'b0, NIL},
    '{OP_FILL,  4'd0,  4'd0,  4'd0,  4'd0,  1'b1, NIL},
    '{OP_QUERY, 4'd0,  4'd0,  4'd0,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd8,  4'd4,  4'd8,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd8,  4'd3,  4'd8,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd8,  4'd9,  4'd8,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd15, 4'd15, 4'd15, 4'd0,  1'b0, NIL},
    '{OP_WRITE, 4'd8,  4'd5,  4'd8,  4'd1,  1'b0, NIL},
    '{OP_QUERY, 4'd8,  4'd5,  4'd8,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd8,  4'd4,  4'd8,  4'd0,  1'b0, NIL},
    '{OP_QUERY, 4'd7,  4'd0,  4'd15, 4'd0,  1'b0, NIL}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [3:0]  in_coord_x = '0;
  logic [3:0]  in_coord_y = '0;
  logic [3:0]  in_coord_z = '0;
  logic [3:0]  in_type_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_type_out;
  logic [5:0]  out_face_mask;
  logic signed [15:0] out_world_x;
  logic [3:0]  out_world_y;
  logic signed [15:0] out_world_z;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [3:0]  vox_ty [16][16][16];
  bit          vox_set [16][16][16];
  logic [3:0]  air_c = 4'd0, stone_c = 4'd1, dirt_c = 4'd2, grass_c = 4'd3;
  logic [11:0] chunk_x = '0, chunk_z = '0;

  answer_t answers_due [$];
  int      errors = 0;
  int      sent = 0;
  bit      idle_en = 1'b1;
  bit      hold_req = 1'b0;
  bit      hold_on = 1'b0;

  voxel_face_visibility_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_type_in(in_type_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_type_out(out_type_out),
    .out_face_mask(out_face_mask), .out_world_x(out_world_x), .out_world_y(out_world_y),
    .out_world_z(out_world_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic bit solid(int x, int y, int z);
    logic [3:0] t;
    t = vox_set[x][y][z] ? vox_ty[x][y][z] : air_c;
    return t != air_c;
  endfunction

  function automatic answer_t apply_command(op_t op, logic [3:0] x, logic [3:0] y,
                                            logic [3:0] z, logic [3:0] tin);
    answer_t a;
    logic [3:0] t;
    int xi, yi, zi;
    a = '0;
    xi = x;
    yi = y;
    zi = z;
    case (op)
      OP_WRITE: begin
        vox_ty[xi][yi][zi] = tin;
        vox_set[xi][yi][zi] = 1'b1;
      end
      OP_QUERY: begin
        t = vox_set[xi][yi][zi] ? vox_ty[xi][yi][zi] : air_c;
        if (t != air_c) begin
          a.mask[0] = !(zi < 15 && solid(xi, yi, zi + 1));
          a.mask[1] = !(zi > 0 && solid(xi, yi, zi - 1));
          a.mask[2] = !(xi > 0 && solid(xi - 1, yi, zi));
          a.mask[3] = !(xi < 15 && solid(xi + 1, yi, zi));
          a.mask[4] = !(yi < 15 && solid(xi, yi + 1, zi));
          a.mask[5] = !(yi > 0 && solid(xi, yi - 1, zi));
        end
        a.ty = t;
        a.wx = {chunk_x, 4'h0} + {12'h000, x};
        a.wy = y;
        a.wz = {chunk_z, 4'h0} + {12'h000, z};
      end
      OP_FILL: begin
        for (int i = 0; i < 16; i++)
          for (int j = 0; j < 16; j++)
            for (int k = 0; k < 16; k++) begin
              if (i == 0 || i == 15 || j == 0 || j == 15 || k == 0 || k == 15)
                vox_ty[i][j][k] = stone_c;
              else if (j < GRASS_LAYER)
                vox_ty[i][j][k] = dirt_c;
              else if (j == GRASS_LAYER)
                vox_ty[i][j][k] = grass_c;
              else
                vox_ty[i][j][k] = air_c;
              vox_set[i][j][k] = 1'b1;
            end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] pick_type();
    case ($urandom_range(0, 4))
      0: return air_c;
      1: return stone_c;
      2: return dirt_c;
      3: return grass_c;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_beat();
    answer_t w;
    if (answers_due.size() == 0) begin
      report("beat with nothing pending", out_type_out, 16'h0);
    end else begin
      w = answers_due.pop_front();
      if (out_type_out !== w.ty) report("type_out", out_type_out, w.ty);
      if (out_face_mask !== w.mask) report("face_mask", out_face_mask, w.mask);
      if (out_world_x !== w.wx) report("world_x", out_world_x, w.wx);
      if (out_world_y !== w.wy) report("world_y", out_world_y, w.wy);
      if (out_world_z !== w.wz) report("world_z", out_world_z, w.wz);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat();
    out_stall <= hold_on || (idle_en && $urandom_range(0, 99) < 27);
  end

  // long receiver hold-off so the queue fills and in_stall rises
  initial forever begin
    wait (hold_req);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (400) @(posedge clk);
    hold_on = 1'b0;
    hold_req = 1'b0;
  end

  task automatic offer(op_t op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                       logic [3:0] tin, bit lit = 1'b0, answer_t lit_ans = '0);
    answer_t a;
    if (idle_en && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_type_in <= tin;
    do @(posedge clk); while (in_stall);
    a = apply_command(op, x, y, z, tin);
    answers_due.push_back(lit ? lit_ans : a);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t r, logic [11:0] v);
    logic [11:0] keep;
    keep = (r == REG_CHUNK_X || r == REG_CHUNK_Z) ? 12'hFFF : 12'h00F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(r) << 2;
    pwdata  <= {20'h0, v & keep};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata[11:0] & keep) !== (v & keep)) report("register readback", prdata[15:0], v & keep);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (r)
      REG_AIR:     air_c   = v[3:0];
      REG_STONE:   stone_c = v[3:0];
      REG_DIRT:    dirt_c  = v[3:0];
      REG_GRASS:   grass_c = v[3:0];
      REG_CHUNK_X: chunk_x = v;
      REG_CHUNK_Z: chunk_z = v;
      default: ;
    endcase
  endtask

  task automatic patch();
    int sz, ox, oy, oz;
    sz = $urandom_range(2, 4);
    ox = $urandom_range(0, 16 - sz);
    oy = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : $urandom_range(0, 16 - sz);
    oz = $urandom_range(0, 16 - sz);
    repeat ($urandom_range(0, 10))
      offer(OP_WRITE, 4'(ox + $urandom_range(0, sz - 1)), 4'(oy + $urandom_range(0, sz - 1)),
            4'(oz + $urandom_range(0, sz - 1)), pick_type());
    for (int i = ox; i < ox + sz; i++)
      for (int j = oy; j < oy + sz; j++)
        for (int k = oz; k < oz + sz; k++) begin
          if ($urandom_range(0, 19) == 0)
            offer(($urandom_range(0, 1) == 1) ? OP_WRITE : OP_NOP, 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pick_type());
          offer(OP_QUERY, 4'(i), 4'(j), 4'(k), 4'($urandom_range(0, 15)));
        end
  endtask

  task automatic noise();
    op_t op;
    repeat ($urandom_range(4, 12)) begin
      op = op_t'($urandom_range(0, 3));
      if (op == OP_FILL && $urandom_range(0, 29) != 0) op = OP_NOP;
      offer(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    logic [11:0] vals [6];
    vox_set = '{default: 1'b0};
    vox_ty  = '{default: 4'd0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++)
      offer(DIR_ROWS[i].op, DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z, DIR_ROWS[i].tin,
            DIR_ROWS[i].known, DIR_ROWS[i].ans);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int r = 0; r < 6; r++) vals[r] = 12'($urandom_range(0, 4095));
      case (ph)
        1: vals = '{12'd15, 12'd0, 12'd8, 12'd15, 12'h800, 12'h7FF};
        2: vals = '{12'd0, 12'd15, 12'd2, 12'd3, 12'h7FF, 12'h800};
        4: begin
          vals[4] = 12'hFFF;
          vals[5] = 12'h001;
        end
        default: ;
      endcase
      if (ph != 0)
        for (int r = 0; r < 6; r++) set_reg(reg_idx_t'(r), vals[r]);
      idle_en = (ph != 3);
      if (ph == 2) hold_req = 1'b1;
      if (ph != 2) offer(OP_FILL, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      while (sent < N_DIR + (ph + 1) * 230) begin
        if ($urandom_range(0, 99) < 75) patch();
        else noise();
      end
    end
    drain();
    if (errors == 0) begin
      $display("** voxel_face_visibility_top: PASSED **");
    end else begin
      $display("** voxel_face_visibility_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("** voxel_face_visibility_top: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/vfv_pkg.sv
rtl/vfv_cfg.sv
rtl/vfv_front.sv
rtl/vfv_queue.sv
rtl/vfv_back.sv
rtl/voxel_face_visibility_top.sv
tb/sv/voxel_face_visibility_top_tb.sv
